FILE: design/ddpd_pkg.sv
// Shared types, widths and constants for the drive-distance PD controller.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ddpd_pkg;

   localparam int MOTORS_AVERAGED_DEF = 6;

   localparam int COUNT_W  = 24;
   localparam int NUM_ENC  = 6;
   localparam int SIDE_ENC = 3;
   localparam int SIDE_W   = COUNT_W + 2;
   localparam int TOTAL_W  = SIDE_W + 1;
   localparam int MAG_W    = 26;
   localparam int REM_W    = 3;
   localparam int FRAC_W   = 8;
   localparam int MEAN_W   = MAG_W + FRAC_W;
   localparam int TQ_W     = 24;
   localparam int ERR_W    = 36;
   localparam int DIFF_W   = ERR_W + 1;
   localparam int DRV_W    = 50;
   localparam int CMD_W    = 8;
   localparam int RELOAD_W = 7;

   localparam int TARGET_W  = 10;
   localparam int CAP_W     = 7;
   localparam int GAIN_W    = 12;
   localparam int SETTLE_W  = 8;
   localparam int TICK_W    = 12;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int REQ_DATA_W  = 152;
   localparam int RSP_DATA_W  = 16;
   localparam int LIMIT_BIT   = NUM_ENC * COUNT_W;

   localparam int NUM_STAGES = 10;

   localparam int COUNTS_PER_INCH_Q8 = 11641;
   localparam int HALF_INCH_Q8       = 5820;
   localparam int MIN_DRIVE          = 15;
   localparam int RELOAD_ON          = 127;
   localparam int Q16_SHIFT          = 16;

   localparam logic [TICK_W-1:0]   TICK_MAX   = '1;
   localparam logic [SETTLE_W-1:0] SETTLE_MAX = '1;

   localparam logic signed [TARGET_W-1:0] TARGET_RST  = '0;
   localparam logic [CAP_W-1:0]           CAP_RST     = CAP_W'(100);
   localparam logic [GAIN_W-1:0]          KP_RST      = GAIN_W'(77);
   localparam logic [GAIN_W-1:0]          KD_RST      = GAIN_W'(512);
   localparam logic [SETTLE_W-1:0]        SETTLE_RST  = SETTLE_W'(7);
   localparam logic [TICK_W-1:0]          TIMEOUT_RST = TICK_W'(250);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TARGET_INCHES = 3'd0,
      REG_DRIVE_CAP     = 3'd1,
      REG_KP_Q8         = 3'd2,
      REG_KD_Q8         = 3'd3,
      REG_SETTLE_TICKS  = 3'd4,
      REG_TIMEOUT_TICKS = 3'd5
   } csr_reg_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic signed [TARGET_W-1:0] target_inches;
      logic [CAP_W-1:0]           drive_cap;
      logic [GAIN_W-1:0]          kp_q8;
      logic [GAIN_W-1:0]          kd_q8;
      logic [SETTLE_W-1:0]        settle_ticks;
      logic [TICK_W-1:0]          timeout_ticks;
   } cfg_type;

   // One load strobe per pipeline stage, the input stage in the lowest bit.
   typedef struct packed {
      logic out;
      logic mag;
      logic add;
      logic mult;
      logic state;
      logic err;
      logic quot;
      logic prod;
      logic sum;
      logic lane;
   } load_type;

   typedef struct packed {
      opcode_type op;
      logic       limit;
   } side_type;

   typedef struct packed {
      logic zero;
      logic done;
      logic limit;
   } flag_type;

endpackage

FILE: design/ddpd_lane.sv
// One side of the drive: adds the encoder counts of that side that take part in the mean.
// Depends on ddpd_pkg.
`timescale 1ns / 1ps

module ddpd_lane #(
   parameter int MOTORS_AVERAGED = ddpd_pkg::MOTORS_AVERAGED_DEF,
   parameter int BASE            = 0
) (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic signed [ddpd_pkg::COUNT_W-1:0]  count [ddpd_pkg::SIDE_ENC],
   output logic signed [ddpd_pkg::SIDE_W-1:0]   side_sum_ff
);

   logic signed [ddpd_pkg::SIDE_W-1:0] side_sum_in;

   always_comb begin
      side_sum_in = '0;
      for (int e = 0; e < ddpd_pkg::SIDE_ENC; e++) begin
         if (BASE + e < MOTORS_AVERAGED) begin
            side_sum_in = side_sum_in + ddpd_pkg::SIDE_W'(count[e]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         side_sum_ff <= side_sum_in;
      end
   end

endmodule

FILE: design/ddpd_mean.sv
// Merges the two side sums and divides by the averaging count with a reciprocal multiply.
// Three stages: sum and magnitude, product, quotient correction. Depends on ddpd_pkg.
`timescale 1ns / 1ps

module ddpd_mean #(
   parameter int MOTORS_AVERAGED = ddpd_pkg::MOTORS_AVERAGED_DEF
) (
   input  logic                                clock,
   input  ddpd_pkg::load_type                  load,
   input  logic signed [ddpd_pkg::SIDE_W-1:0]  left_sum,
   input  logic signed [ddpd_pkg::SIDE_W-1:0]  right_sum,
   output logic [ddpd_pkg::MEAN_W-1:0]         mean_mag,
   output logic                                mean_neg
);

   localparam int MAG_W   = ddpd_pkg::MAG_W;
   localparam int REM_W   = ddpd_pkg::REM_W;
   localparam int FRAC_W  = ddpd_pkg::FRAC_W;
   localparam int RECIP_W = MAG_W + 1;
   localparam int PROD_W  = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << MAG_W) / MOTORS_AVERAGED);
   localparam logic [MAG_W-1:0] DIVISOR = MAG_W'(MOTORS_AVERAGED);

   logic signed [ddpd_pkg::TOTAL_W-1:0] total;
   logic [MAG_W-1:0]  mag1_in, mag1_ff, mag2_ff;
   logic              neg1_ff, neg2_ff, neg3_ff;
   logic [PROD_W-1:0] prod2_in, prod2_ff;
   logic [MAG_W-1:0]  quot0, rem0, quot3_in, quot3_ff, rem_wide;
   logic [REM_W-1:0]  rem3_in, rem3_ff;
   logic [FRAC_W-1:0] frac_lut [2**REM_W];

   for (genvar g = 0; g < 2**REM_W; g++) begin : g_frac
      assign frac_lut[g] = FRAC_W'(((g % MOTORS_AVERAGED) * 256) / MOTORS_AVERAGED);
   end

   always_comb begin
      total   = ddpd_pkg::TOTAL_W'(left_sum) + ddpd_pkg::TOTAL_W'(right_sum);
      mag1_in = total[ddpd_pkg::TOTAL_W-1] ? MAG_W'(-total) : MAG_W'(total);
   end

   assign prod2_in = PROD_W'(mag1_ff) * PROD_W'(RECIP);

   always_comb begin
      quot0    = prod2_ff[MAG_W +: MAG_W];
      rem0     = mag2_ff - MAG_W'(quot0 * DIVISOR);
      quot3_in = quot0;
      rem_wide = rem0;
      if (rem0 >= DIVISOR) begin
         quot3_in = quot0 + MAG_W'(1);
         rem_wide = rem0 - DIVISOR;
      end
      rem3_in = rem_wide[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load.sum) begin
         mag1_ff <= mag1_in;
         neg1_ff <= total[ddpd_pkg::TOTAL_W-1];
      end
      if (load.prod) begin
         prod2_ff <= prod2_in;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
      end
      if (load.quot) begin
         quot3_ff <= quot3_in;
         rem3_ff  <= rem3_in;
         neg3_ff  <= neg2_ff;
      end
   end

   assign mean_mag = {quot3_ff, frac_lut[rem3_ff]};
   assign mean_neg = neg3_ff;

endmodule

FILE: design/ddpd_track.sv
// Position error, move state (previous error, settle and tick counters) and the PD products.
// Three stages: error, state update, multiply. Depends on ddpd_pkg.
`timescale 1ns / 1ps

module ddpd_track (
   input  logic                                clock,
   input  logic                                reset,
   input  ddpd_pkg::load_type                  load,
   input  ddpd_pkg::cfg_type                   cfg,
   input  ddpd_pkg::side_type                  side,
   input  logic [ddpd_pkg::MEAN_W-1:0]         mean_mag,
   input  logic                                mean_neg,
   output logic signed [ddpd_pkg::DRV_W-1:0]   kp_prod_ff,
   output logic signed [ddpd_pkg::DRV_W-1:0]   kd_prod_ff,
   output ddpd_pkg::flag_type                  flag6_ff
);

   localparam int ERR_W  = ddpd_pkg::ERR_W;
   localparam int DIFF_W = ddpd_pkg::DIFF_W;
   localparam int DRV_W  = ddpd_pkg::DRV_W;
   localparam int TQ_W   = ddpd_pkg::TQ_W;
   localparam logic signed [TQ_W-1:0]  CPI      = TQ_W'(ddpd_pkg::COUNTS_PER_INCH_Q8);
   localparam logic signed [ERR_W-1:0] HALF_POS = ERR_W'(ddpd_pkg::HALF_INCH_Q8);
   localparam logic signed [ERR_W-1:0] HALF_NEG = -HALF_POS;

   logic signed [TQ_W-1:0]   target_q8;
   logic signed [ERR_W-1:0]  mean_s, err4_in, err4_ff, err5_ff, prev_in, prev_ff;
   logic signed [DIFF_W-1:0] diff5_in, diff5_ff;
   ddpd_pkg::side_type       side4_ff;
   ddpd_pkg::flag_type       flag5_in, flag5_ff;
   logic [ddpd_pkg::SETTLE_W-1:0] settle_in, settle_ff, settle_next;
   logic [ddpd_pkg::TICK_W-1:0]   tick_in, tick_ff;
   logic                          fin_in, fin_ff, close;
   logic signed [DRV_W-1:0]       kp_prod_in, kd_prod_in;

   always_comb begin
      target_q8 = TQ_W'(cfg.target_inches) * CPI;
      mean_s    = $signed(ERR_W'(mean_mag));
      err4_in   = mean_neg ? ERR_W'(target_q8) + mean_s : ERR_W'(target_q8) - mean_s;
   end

   always_comb begin
      close       = (err4_ff <= HALF_POS) && (err4_ff >= HALF_NEG);
      settle_next = (close && settle_ff != ddpd_pkg::SETTLE_MAX) ?
                    settle_ff + ddpd_pkg::SETTLE_W'(1) : settle_ff;
      diff5_in    = DIFF_W'(err4_ff) - DIFF_W'(prev_ff);
      prev_in     = prev_ff;
      settle_in   = settle_ff;
      tick_in     = tick_ff;
      fin_in      = fin_ff;
      flag5_in    = '{zero: 1'b1, done: 1'b0, limit: side4_ff.limit};
      if (load.state) begin
         if (side4_ff.op == ddpd_pkg::OP_START) begin
            prev_in   = '0;
            settle_in = '0;
            tick_in   = '0;
            fin_in    = 1'b0;
         end else if (!fin_ff) begin
            prev_in = err4_ff;
            if (tick_ff > cfg.timeout_ticks) begin
               flag5_in.done = 1'b1;
               fin_in        = 1'b1;
            end else begin
               tick_in   = (tick_ff == ddpd_pkg::TICK_MAX) ?
                           tick_ff : tick_ff + ddpd_pkg::TICK_W'(1);
               settle_in = settle_next;
               if (settle_next >= cfg.settle_ticks) begin
                  flag5_in.done = 1'b1;
                  fin_in        = 1'b1;
               end else begin
                  flag5_in.zero = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      kp_prod_in = DRV_W'(err5_ff) * DRV_W'($signed({1'b0, cfg.kp_q8}));
      kd_prod_in = DRV_W'(diff5_ff) * DRV_W'($signed({1'b0, cfg.kd_q8}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         settle_ff <= '0;
         tick_ff   <= '0;
         fin_ff    <= 1'b1;
      end else begin
         prev_ff   <= prev_in;
         settle_ff <= settle_in;
         tick_ff   <= tick_in;
         fin_ff    <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.err) begin
         err4_ff  <= err4_in;
         side4_ff <= side;
      end
      if (load.state) begin
         err5_ff  <= err4_ff;
         diff5_ff <= diff5_in;
         flag5_ff <= flag5_in;
      end
      if (load.mult) begin
         kp_prod_ff <= kp_prod_in;
         kd_prod_ff <= kd_prod_in;
         flag6_ff   <= flag5_ff;
      end
   end

   // Move state changes only when a word passes the state stage.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(load.state) |-> $stable(tick_ff) && $stable(settle_ff) && $stable(fin_ff))
      else $error("move state changed without a word in the state stage");

   // A tick after the move has finished gives a zero result and never a second done.
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      (load.state && fin_ff && side4_ff.op == ddpd_pkg::OP_TICK)
      |=> flag5_ff.zero && !flag5_ff.done)
      else $error("tick after finish produced drive or done");

endmodule

FILE: design/ddpd_shape.sv
// Sums the PD terms, clamps to the drive cap, lifts to the minimum drive and forms the result.
// Three stages: add, magnitude, output register. Depends on ddpd_pkg.
`timescale 1ns / 1ps

module ddpd_shape (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ddpd_pkg::load_type                   load,
   input  logic [ddpd_pkg::CAP_W-1:0]           drive_cap,
   input  logic signed [ddpd_pkg::DRV_W-1:0]    kp_prod,
   input  logic signed [ddpd_pkg::DRV_W-1:0]    kd_prod,
   input  ddpd_pkg::flag_type                   flag,
   input  logic                                 out_valid,
   output logic signed [ddpd_pkg::CMD_W-1:0]    cmd_ff,
   output logic [ddpd_pkg::RELOAD_W-1:0]        reload_ff,
   output logic                                 done_ff
);

   localparam int DRV_W = ddpd_pkg::DRV_W;
   localparam int CAP_W = ddpd_pkg::CAP_W;
   localparam int CMD_W = ddpd_pkg::CMD_W;
   localparam logic [CAP_W-1:0] MIN_DRIVE = CAP_W'(ddpd_pkg::MIN_DRIVE);
   localparam logic signed [CMD_W-1:0] CMD_MOST_NEG = {1'b1, {(CMD_W-1){1'b0}}};

   logic signed [DRV_W-1:0] sum7_ff;
   ddpd_pkg::flag_type      flag7_ff, flag8_ff;
   logic [DRV_W-1:0]        mag8_in, mag8_ff, cap_q16;
   logic                    neg8_ff;
   logic [CAP_W-1:0]        clamped, lifted;
   logic signed [CMD_W-1:0] cmd_in;
   logic [ddpd_pkg::RELOAD_W-1:0] reload_in;

   assign mag8_in = sum7_ff[DRV_W-1] ? DRV_W'(-sum7_ff) : DRV_W'(sum7_ff);

   always_comb begin
      cap_q16 = DRV_W'(drive_cap) << ddpd_pkg::Q16_SHIFT;
      clamped = (mag8_ff > cap_q16) ? drive_cap : mag8_ff[ddpd_pkg::Q16_SHIFT +: CAP_W];
      lifted  = (clamped < MIN_DRIVE) ? MIN_DRIVE : clamped;
      if (mag8_ff == '0 || drive_cap == '0) begin
         lifted = '0;
      end
      cmd_in = neg8_ff ? -$signed(CMD_W'(lifted)) : $signed(CMD_W'(lifted));
      if (flag8_ff.zero) begin
         cmd_in = '0;
      end
      reload_in = (flag8_ff.zero || flag8_ff.limit) ? '0 :
                  ddpd_pkg::RELOAD_W'(ddpd_pkg::RELOAD_ON);
   end

   always_ff @(posedge clock) begin
      if (load.add) begin
         sum7_ff  <= kp_prod + kd_prod;
         flag7_ff <= flag;
      end
      if (load.mag) begin
         mag8_ff  <= mag8_in;
         neg8_ff  <= sum7_ff[DRV_W-1];
         flag8_ff <= flag7_ff;
      end
      if (load.out) begin
         cmd_ff    <= cmd_in;
         reload_ff <= reload_in;
         done_ff   <= flag8_ff.done;
      end
   end

   // The finishing word carries no drive and no reload.
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      out_valid && done_ff |-> cmd_ff == '0 && reload_ff == '0)
      else $error("finishing word carries drive or reload");

   // The command stays symmetric, so the most negative code never appears.
   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> cmd_ff != CMD_MOST_NEG)
      else $error("drive command out of range");

endmodule

FILE: design/drive_distance_pd_controller_unit.sv
// Top level of the drive-distance PD controller: stream ports, register file, stage control.
// Depends on ddpd_pkg, ddpd_lane, ddpd_mean, ddpd_track and ddpd_shape.
//
// Input words arrive on req_*: req_tuser is the opcode (start or tick), req_tdata the six
// encoder counts and the limit switch. Every input word gives exactly one result word on
// rsp_*: drive command and reload command in rsp_tdata, rsp_tlast set on the tick that
// finishes the move. Registers are written on csr_* (index, data); csr_ready is always high,
// and writes are meant to happen only while no word is in flight.
// One word is accepted per cycle while rsp_tready does not stall the pipeline.
// The first two stages are the side lanes and their merge; the mean is then formed by a
// reciprocal multiply and a one-step correction, and the PD products and the clamp follow.
// Each stage holds a word until the next one is free, so a stalled rsp_tready fills the
// empty stages first and req_tready drops only when all ten stages hold words.
// Reset loads the register defaults, empties the pipeline and leaves the move finished,
// so ticks give zero results until a start word arrives.
`timescale 1ns / 1ps

module drive_distance_pd_controller_unit #(
   parameter int MOTORS_AVERAGED = ddpd_pkg::MOTORS_AVERAGED_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: left_front_count, left_mid_count, left_back_count,
   // right_front_count, right_mid_count, right_back_count, limit_pressed, zero fill.
   input  logic [ddpd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Fields from bit 0: opcode.
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: drive_cmd, reload_cmd, zero fill.
   output logic [ddpd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ddpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ddpd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int NS = ddpd_pkg::NUM_STAGES;
   localparam int CW = ddpd_pkg::COUNT_W;

   ddpd_pkg::cfg_type  cfg_in, cfg_ff;
   logic [NS-1:0]      valid_in, valid_ff, valid_up, load_vec;
   logic [NS:0]        ready;
   ddpd_pkg::load_type load;
   ddpd_pkg::side_type side_ff [4];
   ddpd_pkg::side_type req_side;

   logic signed [CW-1:0] left_counts  [ddpd_pkg::SIDE_ENC];
   logic signed [CW-1:0] right_counts [ddpd_pkg::SIDE_ENC];
   logic signed [ddpd_pkg::SIDE_W-1:0] left_sum, right_sum;
   logic [ddpd_pkg::MEAN_W-1:0] mean_mag;
   logic                        mean_neg;
   logic signed [ddpd_pkg::DRV_W-1:0] kp_prod, kd_prod;
   ddpd_pkg::flag_type          flag6;
   logic signed [ddpd_pkg::CMD_W-1:0] cmd;
   logic [ddpd_pkg::RELOAD_W-1:0]     reload;
   logic                              done;

   // Register file.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (ddpd_pkg::csr_reg_type'(csr_index))
            ddpd_pkg::REG_TARGET_INCHES:
               cfg_in.target_inches = $signed(csr_data[ddpd_pkg::TARGET_W-1:0]);
            ddpd_pkg::REG_DRIVE_CAP:     cfg_in.drive_cap = csr_data[ddpd_pkg::CAP_W-1:0];
            ddpd_pkg::REG_KP_Q8:         cfg_in.kp_q8 = csr_data[ddpd_pkg::GAIN_W-1:0];
            ddpd_pkg::REG_KD_Q8:         cfg_in.kd_q8 = csr_data[ddpd_pkg::GAIN_W-1:0];
            ddpd_pkg::REG_SETTLE_TICKS:
               cfg_in.settle_ticks = csr_data[ddpd_pkg::SETTLE_W-1:0];
            ddpd_pkg::REG_TIMEOUT_TICKS:
               cfg_in.timeout_ticks = csr_data[ddpd_pkg::TICK_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{target_inches: ddpd_pkg::TARGET_RST,
                     drive_cap:     ddpd_pkg::CAP_RST,
                     kp_q8:         ddpd_pkg::KP_RST,
                     kd_q8:         ddpd_pkg::KD_RST,
                     settle_ticks:  ddpd_pkg::SETTLE_RST,
                     timeout_ticks: ddpd_pkg::TIMEOUT_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stage control: a stage takes a word when it is empty or its own word moves on.
   always_comb begin
      ready[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k + 1];
      end
      valid_up[0] = req_tvalid;
      for (int k = 1; k < NS; k++) begin
         valid_up[k] = valid_ff[k - 1];
      end
      for (int k = 0; k < NS; k++) begin
         load_vec[k] = valid_up[k] && ready[k];
         valid_in[k] = ready[k] ? valid_up[k] : valid_ff[k];
      end
   end

   assign load = ddpd_pkg::load_type'(load_vec);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[NS-1];

   // Opcode and limit switch travel alongside the lane and mean stages.
   assign req_side = '{op: ddpd_pkg::opcode_type'(req_tuser),
                       limit: req_tdata[ddpd_pkg::LIMIT_BIT]};

   always_ff @(posedge clock) begin
      if (load.lane) begin
         side_ff[0] <= req_side;
      end
      if (load.sum) begin
         side_ff[1] <= side_ff[0];
      end
      if (load.prod) begin
         side_ff[2] <= side_ff[1];
      end
      if (load.quot) begin
         side_ff[3] <= side_ff[2];
      end
   end

   always_comb begin
      for (int e = 0; e < ddpd_pkg::SIDE_ENC; e++) begin
         left_counts[e]  = $signed(req_tdata[e * CW +: CW]);
         right_counts[e] = $signed(req_tdata[(e + ddpd_pkg::SIDE_ENC) * CW +: CW]);
      end
   end

   ddpd_lane #(.MOTORS_AVERAGED(MOTORS_AVERAGED), .BASE(0)) u_lane_left (
      .clock       (clock),
      .load        (load.lane),
      .count       (left_counts),
      .side_sum_ff (left_sum)
   );

   ddpd_lane #(.MOTORS_AVERAGED(MOTORS_AVERAGED), .BASE(ddpd_pkg::SIDE_ENC)) u_lane_right (
      .clock       (clock),
      .load        (load.lane),
      .count       (right_counts),
      .side_sum_ff (right_sum)
   );

   ddpd_mean #(.MOTORS_AVERAGED(MOTORS_AVERAGED)) u_mean (
      .clock     (clock),
      .load      (load),
      .left_sum  (left_sum),
      .right_sum (right_sum),
      .mean_mag  (mean_mag),
      .mean_neg  (mean_neg)
   );

   ddpd_track u_track (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .cfg        (cfg_ff),
      .side       (side_ff[3]),
      .mean_mag   (mean_mag),
      .mean_neg   (mean_neg),
      .kp_prod_ff (kp_prod),
      .kd_prod_ff (kd_prod),
      .flag6_ff   (flag6)
   );

   ddpd_shape u_shape (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .drive_cap (cfg_ff.drive_cap),
      .kp_prod   (kp_prod),
      .kd_prod   (kd_prod),
      .flag      (flag6),
      .out_valid (rsp_tvalid),
      .cmd_ff    (cmd),
      .reload_ff (reload),
      .done_ff   (done)
   );

   assign rsp_tdata = {1'b0, reload, cmd};
   assign rsp_tlast = done;

endmodule
